### design/hbd_pkg.sv
// Shared constants, register codes and controller/datapath handshake types.
package hbd_pkg;

  // Field widths fixed by the block's interface
  localparam int CNT_W       = 16;
  localparam int TH_W        = 12;
  localparam int BEAT_SMP_W  = 12;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  // Parameter defaults
  localparam int HISTORY_DEPTH_DEF = 10;
  localparam int SAMPLE_BITS_DEF   = 12;

  // Register reset values
  localparam logic [TH_W-1:0]  LOW_TH_RST    = 12'd1683;
  localparam logic [TH_W-1:0]  HIGH_TH_RST   = 12'd1882;
  localparam logic [TH_W-1:0]  REL_TH_RST    = 12'd1753;
  localparam logic [CNT_W-1:0] LOW_NEED_RST  = 16'd10;
  localparam logic [CNT_W-1:0] HIGH_NEED_RST = 16'd20;
  localparam logic [CNT_W-1:0] TPM_RST       = 16'd6000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_TH    = 3'd0,
    CFG_HIGH_TH   = 3'd1,
    CFG_REL_TH    = 3'd2,
    CFG_LOW_NEED  = 3'd3,
    CFG_HIGH_NEED = 3'd4,
    CFG_TPM       = 3'd5
  } cfg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic item_go;    // input item accepted this cycle
    logic ring_upd;   // write interval to ring, update running sum
    logic avg_cap;    // capture average from the reciprocal multiply
    logic div_start;  // launch the divider on tpm / average
    logic bpm_cap;    // capture bpm from divider
    logic out_load;   // load output register
  } hbd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic beat;       // accepted sample completes a beat
    logic div_done;   // divider quotient ready
    logic avg_zero;   // captured average is zero
  } hbd_sts_t;

endpackage

### design/hbd_if.sv
// Valid/ready channel interfaces for sensor items and beat results.
interface hbd_in_if #(
  parameter int SAMPLE_BITS = hbd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface hbd_out_if;
  import hbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CNT_W-1:0]      bpm;
  logic [CNT_W-1:0]      average_interval;
  logic [BEAT_SMP_W-1:0] beat_sample;
  logic                  zero_interval;

  modport source (output valid, output bpm, output average_interval,
                  output beat_sample, output zero_interval, input ready);
  modport sink   (input valid, input bpm, input average_interval,
                  input beat_sample, input zero_interval, output ready);
endinterface

### design/heart_beat_detect_bpm.sv
// Top level of the pulse-sensor beat detector and BPM calculator.
//
// in_ch carries timer ticks (req_type 1) and sensor samples (req_type 0).
// A tick or a sample that completes no beat is taken in the idle state; in_ch.ready
// stays high for it. A sample that completes a beat starts a sequence that
// updates the interval ring and its running sum, takes the average by a
// multiply with the reciprocal of HISTORY_DEPTH, and then divides
// ticks_per_minute by that average on a one-bit-per-cycle divider, which is
// skipped on a zero average. in_ch.ready is low during that sequence.
// out_ch holds one result in an output register; while it waits, ticks and
// samples are still taken, and only the next beat stalls at its handoff
// until the receiver takes the held result.
// Reset (rst_n low, synchronous) loads the default thresholds, clears the
// counters and marks every ring entry as zero; no clearing pass is needed.
// cfg_we writes register cfg_index with cfg_wdata; write only while idle.
module heart_beat_detect_bpm #(
  parameter int HISTORY_DEPTH = hbd_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = hbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hbd_in_if.sink                         in_ch,
  hbd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [hbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hbd_pkg::*;

  hbd_cmd_t cmd;
  hbd_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  // Sequencing
  hbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  hbd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_req_type          (in_ch.req_type),
    .in_sample            (in_ch.sample),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_bpm              (out_ch.bpm),
    .out_average_interval (out_ch.average_interval),
    .out_beat_sample      (out_ch.beat_sample),
    .out_zero_interval    (out_ch.zero_interval)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // A zero average always comes with a saturated bpm
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_interval |-> out_ch.bpm == 16'hFFFF)
    else $error("zero_interval without saturated bpm");

  // The flag tracks the average exactly
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.zero_interval == (out_ch.average_interval == 16'd0))
    else $error("zero_interval disagrees with average_interval");

  // A division never finishes in the cycle after launch
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done too early");

  // No input is taken while the ring is updated
  a_ring_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ring_upd |-> !in_ch.ready)
    else $error("input accepted during ring update");
endmodule

### design/hbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

### design/hbd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module hbd_div #(
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW:0]   shifted;
  logic          fits;

  // Shift in next dividend bit, subtract when it fits
  always_comb begin
    shifted  = {rem_r, quo_r[DW-1]};
    fits     = (shifted >= {1'b0, dvs_r});
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt = CW'(DW);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
      rem_nxt  = fits ? DW'(shifted - {1'b0, dvs_r}) : DW'(shifted);
      quo_nxt  = {quo_r[DW-2:0], fits};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

### design/hbd_ctrl.sv
// Beat sequencing controller: ring update, average, bpm division, output handoff.
module hbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hbd_pkg::hbd_sts_t sts,
  output hbd_pkg::hbd_cmd_t cmd
);
  import hbd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_RING     = 6'b000010,
    ST_AVG      = 6'b000100,
    ST_CHK      = 6'b001000,
    ST_BPM_WAIT = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.item_go  = in_valid;
        if (in_valid && sts.beat) begin
          state_nxt = ST_RING;
        end
      end
      ST_RING: begin
        cmd.ring_upd = 1'b1;
        state_nxt    = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg_cap = 1'b1;
        state_nxt   = ST_CHK;
      end
      ST_CHK: begin
        if (sts.avg_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_BPM_WAIT;
        end
      end
      ST_BPM_WAIT: begin
        if (sts.div_done) begin
          cmd.bpm_cap = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: drop on take, raise on load
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

### design/hbd_dp.sv
// Datapath: config registers, phase counters, interval ring, averaging and BPM.
module hbd_dp #(
  parameter int HISTORY_DEPTH = hbd_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = hbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_req_type,
  input  logic [SAMPLE_BITS-1:0]           in_sample,
  input  hbd_pkg::hbd_cmd_t                cmd,
  output hbd_pkg::hbd_sts_t                sts,
  output logic [hbd_pkg::CNT_W-1:0]        out_bpm,
  output logic [hbd_pkg::CNT_W-1:0]        out_average_interval,
  output logic [hbd_pkg::BEAT_SMP_W-1:0]   out_beat_sample,
  output logic                             out_zero_interval
);
  import hbd_pkg::*;

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W  = CNT_W + $clog2(HISTORY_DEPTH);
  localparam int CMP_W  = (SAMPLE_BITS > TH_W) ? SAMPLE_BITS : TH_W;
  // Reciprocal of the depth: (sum * RCP) >> RCP_SH equals sum / depth for any sum
  localparam int             RCP_SH = SUM_W + $clog2(HISTORY_DEPTH);
  localparam logic [SUM_W:0] RCP    =
    (SUM_W + 1)'(((64'd1 << RCP_SH) / HISTORY_DEPTH) + 1);

  // Configuration registers
  logic [TH_W-1:0]  low_th_r, high_th_r, rel_th_r;
  logic [CNT_W-1:0] low_need_r, high_need_r, tpm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_th_r    <= LOW_TH_RST;
      high_th_r   <= HIGH_TH_RST;
      rel_th_r    <= REL_TH_RST;
      low_need_r  <= LOW_NEED_RST;
      high_need_r <= HIGH_NEED_RST;
      tpm_r       <= TPM_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOW_TH:    low_th_r    <= TH_W'(cfg_wdata);
        CFG_HIGH_TH:   high_th_r   <= TH_W'(cfg_wdata);
        CFG_REL_TH:    rel_th_r    <= TH_W'(cfg_wdata);
        CFG_LOW_NEED:  low_need_r  <= cfg_wdata;
        CFG_HIGH_NEED: high_need_r <= cfg_wdata;
        CFG_TPM:       tpm_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Phase detection on the incoming sample
  logic [CNT_W-1:0] low_r, high_r, ival_r;
  logic [CNT_W-1:0] low1, high1;
  logic [CMP_W-1:0] smp;
  logic             beat;

  always_comb begin
    smp   = CMP_W'(in_sample);
    low1  = low_r;
    high1 = high_r;
    if (smp < CMP_W'(low_th_r)) begin
      low1 = (low_r == '1) ? low_r : low_r + CNT_W'(1);
    end
    if ((low1 > low_need_r) && (smp > CMP_W'(high_th_r))) begin
      high1 = (high_r == '1) ? high_r : high_r + CNT_W'(1);
    end
    beat = !in_req_type && (high1 > high_need_r) && (smp < CMP_W'(rel_th_r));
  end

  // Counters: advance on accepted items, restart on a heart beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
      ival_r <= '0;
    end else if (cmd.item_go) begin
      if (in_req_type) begin
        ival_r <= (ival_r == '1) ? ival_r : ival_r + CNT_W'(1);
      end else if (beat) begin
        low_r  <= '0;
        high_r <= '0;
        ival_r <= '0;
      end else begin
        low_r  <= low1;
        high_r <= high1;
      end
    end
  end

  // Hold the finished interval and the beat sample
  logic [CNT_W-1:0]      ival_cap_r;
  logic [BEAT_SMP_W-1:0] beat_smp_r;

  always_ff @(posedge clk) begin
    if (cmd.item_go && beat) begin
      ival_cap_r <= ival_r;
      beat_smp_r <= BEAT_SMP_W'(in_sample);
    end
  end

  // Interval ring with per-entry valid bits and a running sum
  logic [SLOT_W-1:0]        slot_r;
  logic [HISTORY_DEPTH-1:0] vld_r;
  logic [SUM_W-1:0]         sum_r;
  logic [CNT_W-1:0]         ram_rdata;
  logic [CNT_W-1:0]         old_ival;

  hbd_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HISTORY_DEPTH),
    .AW    (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.ring_upd),
    .waddr (slot_r),
    .wdata (ival_cap_r),
    .re    (cmd.item_go),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign old_ival = vld_r[slot_r] ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      vld_r  <= '0;
      sum_r  <= '0;
    end else if (cmd.ring_upd) begin
      vld_r[slot_r] <= 1'b1;
      slot_r <= (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
      sum_r  <= SUM_W'(({1'b0, sum_r} - (SUM_W + 1)'(old_ival))
                       + (SUM_W + 1)'(ival_cap_r));
    end
  end

  // Average: ring sum times the reciprocal of the depth
  logic [2*SUM_W:0] avg_prod;
  logic [CNT_W-1:0] avg_r, bpm_r;
  logic [CNT_W-1:0] div_quo;
  logic             div_done;

  assign avg_prod = (2*SUM_W + 1)'(sum_r) * (2*SUM_W + 1)'(RCP);

  // Divider: ticks_per_minute / average
  hbd_div #(
    .DW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tpm_r),
    .divisor  (avg_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.avg_cap) begin
      avg_r <= avg_prod[RCP_SH +: CNT_W];
    end
    if (cmd.bpm_cap) begin
      bpm_r <= div_quo;
    end
  end

  // Output register: saturate bpm on a zero average
  logic [CNT_W-1:0]      o_bpm_r, o_avg_r;
  logic [BEAT_SMP_W-1:0] o_smp_r;
  logic                  o_zero_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_bpm_r  <= (avg_r == '0) ? '1 : bpm_r;
      o_avg_r  <= avg_r;
      o_smp_r  <= beat_smp_r;
      o_zero_r <= (avg_r == '0);
    end
  end

  assign sts.beat     = beat;
  assign sts.div_done = div_done;
  assign sts.avg_zero = (avg_r == '0);

  assign out_bpm              = o_bpm_r;
  assign out_average_interval = o_avg_r;
  assign out_beat_sample      = o_smp_r;
  assign out_zero_interval    = o_zero_r;
endmodule
